>>> rtl/core/unix_millis_to_civil_date_macros.svh
// assertion macros shared by the timestamp converter rtl
`ifndef UNIX_MILLIS_TO_CIVIL_DATE_MACROS_SVH
`define UNIX_MILLIS_TO_CIVIL_DATE_MACROS_SVH

`ifndef SYNTHESIS
`define UMCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define UMCD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define UMCD_ASSERT(lbl, prop, msg)
`define UMCD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/core/umcd_pkg.sv
// shared types, constants and tables of the timestamp converter
`timescale 1ns / 1ps

package umcd_pkg;

    localparam int IN_W   = 54;
    localparam int CFG_W  = 12;
    localparam int DAY_W  = 28;
    localparam int MSD_W  = 27;
    localparam int YEAR_W = 20;

    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = DAY_W / DIV_STEPS;

    localparam longint DAYS_PER_ERA  = 146097;
    localparam longint DAYS_PER_CENT = 36524;
    localparam longint CIVIL_SHIFT   = 719468;
    localparam longint ERA_BIAS      = 700;
    localparam longint MS_PER_DAY    = 86400000;
    localparam longint MS_PER_MIN    = 60000;
    localparam longint MS_PER_SEC    = 1000;
    localparam longint SEC_PER_HOUR  = 3600;
    localparam longint SEC_PER_MIN   = 60;
    localparam longint DAYS_PER_YEAR = 365;
    localparam longint BIAS_DAYS     = ERA_BIAS * DAYS_PER_ERA + CIVIL_SHIFT;

    localparam logic signed [IN_W-1:0] MS_LIMIT     = 54'sd8640000000000000;
    localparam logic signed [IN_W-1:0] MS_NEG_LIMIT = -54'sd8640000000000000;
    localparam logic [IN_W-1:0]        BIAS_MS      = 54'(BIAS_DAYS * MS_PER_DAY);
    localparam logic [MSD_W-1:0]       DAY_MS       = 27'(MS_PER_DAY);

    // reciprocals for exact floor division: ceil(2^sh / d) with sh = width + ceil(log2 d)
    localparam int ERA_SH  = 46;
    localparam int SEC_SH  = 37;
    localparam int HOUR_SH = 29;
    localparam int MIN_SH  = 18;
    localparam int QUAD_SH = 29;
    localparam int YEAR_SH = 27;

    localparam logic [28:0] ERA_MUL  =
        29'(((64'd1 << ERA_SH) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA));
    localparam logic [27:0] SEC_MUL  =
        28'(((64'd1 << SEC_SH) + 64'(MS_PER_SEC) - 64'd1) / 64'(MS_PER_SEC));
    localparam logic [17:0] HOUR_MUL =
        18'(((64'd1 << HOUR_SH) + 64'(SEC_PER_HOUR) - 64'd1) / 64'(SEC_PER_HOUR));
    localparam logic [12:0] MIN_MUL  =
        13'(((64'd1 << MIN_SH) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN));
    localparam logic [18:0] QUAD_MUL =
        19'(((64'd1 << QUAD_SH) + 64'd1460 - 64'd1) / 64'd1460);
    localparam logic [18:0] YEAR_MUL =
        19'(((64'd1 << YEAR_SH) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));

    typedef struct packed {
        logic            oor;
        logic [IN_W-1:0] ms_biased;
    } div_in_t;

    typedef struct packed {
        logic             oor;
        logic [DAY_W-1:0] day_num;
        logic [MSD_W-1:0] ms_of_day;
    } div_out_t;

    typedef struct packed {
        logic signed [YEAR_W-1:0] cal_year;
        logic [3:0]               cal_month;
        logic [4:0]               cal_day;
        logic [4:0]               clock_hour;
        logic [5:0]               clock_minute;
        logic [5:0]               clock_second;
        logic [9:0]               milli_part;
        logic                     out_of_range;
    } result_t;

    // first day of each month in a march-based year
    function automatic logic [8:0] day_base(input logic [3:0] mp);
        logic [8:0] base;
        case (mp)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd92;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd153;
            4'd6:    base = 9'd184;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd245;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd306;
            4'd11:   base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

>>> rtl/core/umcd_front.sv
// zone offset register, range check and biased millisecond count
`timescale 1ns / 1ps

module umcd_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wvalid,
    output logic                                cfg_wready,
    input  logic signed [umcd_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [umcd_pkg::IN_W-1:0]    in_epoch_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output umcd_pkg::div_in_t                   out_word
);

    localparam int IN_W = umcd_pkg::IN_W;

    logic [IN_W-1:0]    zone_term_reg;
    logic [IN_W-1:0]    zone_term_next;
    logic signed [27:0] zone_prod;
    logic               v_reg;
    umcd_pkg::div_in_t  word_reg;
    umcd_pkg::div_in_t  word_next;

    assign cfg_wready = 1'b1;

    // offset in ms plus the bias that keeps the sum non-negative
    assign zone_prod      = 28'(cfg_wdata) * 28'(umcd_pkg::MS_PER_MIN);
    assign zone_term_next = umcd_pkg::BIAS_MS + IN_W'(zone_prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_term_reg <= umcd_pkg::BIAS_MS;
        end else if (cfg_wvalid && cfg_wready) begin
            zone_term_reg <= zone_term_next;
        end
    end

    always_comb begin
        word_next.oor       = (in_epoch_ms > umcd_pkg::MS_LIMIT) ||
                              (in_epoch_ms < umcd_pkg::MS_NEG_LIMIT);
        word_next.ms_biased = IN_W'(55'(in_epoch_ms) + 55'(zone_term_reg));
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = v_reg;
    assign out_word  = word_reg;

endmodule

>>> rtl/core/umcd_daydiv.sv
// pipelined restoring division of the biased count by the day length
`timescale 1ns / 1ps

`include "unix_millis_to_civil_date_macros.svh"

module umcd_daydiv (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  umcd_pkg::div_in_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output umcd_pkg::div_out_t out_word
);

    localparam int IN_W   = umcd_pkg::IN_W;
    localparam int DAY_W  = umcd_pkg::DAY_W;
    localparam int MSD_W  = umcd_pkg::MSD_W;
    localparam int STEPS  = umcd_pkg::DIV_STEPS;
    localparam int STAGES = umcd_pkg::DIV_STAGES;
    localparam logic [MSD_W-1:0] DAY_MS = umcd_pkg::DAY_MS;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] en;
    logic [STAGES-1:0] oor_reg;
    logic [STAGES-1:0] oor_next;
    logic [MSD_W-1:0]  rem_reg  [STAGES];
    logic [MSD_W-1:0]  rem_next [STAGES];
    logic [DAY_W-1:0]  low_reg  [STAGES];
    logic [DAY_W-1:0]  low_next [STAGES];

    // a stage loads when empty or when the stage after it moves
    always_comb begin
        en[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];
    assign v_next   = {v_reg[STAGES-2:0], in_valid};
    assign oor_next = {oor_reg[STAGES-2:0], in_word.oor};

    // low word shifts out dividend bits and takes in quotient bits
    always_comb begin
        logic [MSD_W:0]   trial;
        logic [MSD_W-1:0] r;
        logic [DAY_W-1:0] l;
        trial = '0;
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                r = MSD_W'(in_word.ms_biased[IN_W-1:DAY_W]);
                l = in_word.ms_biased[DAY_W-1:0];
            end else begin
                r = rem_reg[k-1];
                l = low_reg[k-1];
            end
            for (int i = 0; i < STEPS; i++) begin
                trial = {r, l[DAY_W-1]};
                l     = {l[DAY_W-2:0], 1'b0};
                if (trial >= {1'b0, DAY_MS}) begin
                    trial = trial - {1'b0, DAY_MS};
                    l[0]  = 1'b1;
                end
                r = trial[MSD_W-1:0];
            end
            rem_next[k] = r;
            low_next[k] = l;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (en[k]) begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                oor_reg[k] <= oor_next[k];
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];

    always_comb begin
        out_word.oor       = oor_reg[STAGES-1];
        out_word.day_num   = low_reg[STAGES-1];
        out_word.ms_of_day = rem_reg[STAGES-1];
    end

    `UMCD_ASSERT(a_rem_below_day, out_valid |-> out_word.ms_of_day < DAY_MS, "day remainder too large")

endmodule

>>> rtl/core/umcd_civil.sv
// calendar and clock pipeline from day number and ms of day
`timescale 1ns / 1ps

`include "unix_millis_to_civil_date_macros.svh"

module umcd_civil (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  umcd_pkg::div_out_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output umcd_pkg::result_t  out_word
);

    localparam int DAY_W  = umcd_pkg::DAY_W;
    localparam int MSD_W  = umcd_pkg::MSD_W;
    localparam int YEAR_W = umcd_pkg::YEAR_W;

    localparam int ST_SPLIT = 0;
    localparam int ST_DOE   = 1;
    localparam int ST_CENT  = 2;
    localparam int ST_SUM   = 3;
    localparam int ST_YOE   = 4;
    localparam int ST_DOY   = 5;
    localparam int ST_MP    = 6;
    localparam int ST_DATE  = 7;
    localparam int STAGES   = 8;

    localparam logic [17:0] DOE_END = 18'(umcd_pkg::DAYS_PER_ERA);

    typedef struct packed {
        logic                     oor;
        logic [DAY_W-1:0]         q;
        logic [MSD_W-1:0]         msd;
        logic [10:0]              era;
        logic signed [YEAR_W-1:0] era_years;
        logic [17:0]              doe;
        logic [6:0]               a;
        logic [2:0]               b;
        logic                     c;
        logic [17:0]              t;
        logic [8:0]               yoe;
        logic [8:0]               doy;
        logic [3:0]               mp;
        logic [16:0]              sod;
        logic [9:0]               millis;
        logic [4:0]               hour;
        logic [11:0]              trem;
        logic [5:0]               minute;
        logic [5:0]               second;
        logic signed [YEAR_W-1:0] year;
        logic [3:0]               month;
        logic [4:0]               day;
    } civ_t;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] en;
    civ_t              st_reg  [STAGES];
    civ_t              st_next [STAGES];

    always_comb begin
        en[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];
    assign v_next   = {v_reg[STAGES-2:0], in_valid};

    always_comb begin
        civ_t                     c;
        logic [56:0]              era_prod;
        logic [54:0]              sec_prod;
        logic [34:0]              hour_prod;
        logic [36:0]              quad_prod;
        logic [24:0]              min_prod;
        logic [36:0]              year_prod;
        logic signed [YEAR_W-1:0] era_off;
        logic [1:0]               cent;
        logic [17:0]              yday;
        logic [3:0]               mp_v;
        logic [2:0]               b_v;
        era_prod  = '0;
        sec_prod  = '0;
        hour_prod = '0;
        quad_prod = '0;
        min_prod  = '0;
        year_prod = '0;
        era_off   = '0;
        cent      = '0;
        yday      = '0;
        mp_v      = '0;
        b_v       = '0;
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                c     = '0;
                c.oor = in_word.oor;
                c.q   = in_word.day_num;
                c.msd = in_word.ms_of_day;
            end else begin
                c = st_reg[k-1];
            end
            case (k)
                ST_SPLIT: begin
                    era_prod = 57'(c.q) * 57'(umcd_pkg::ERA_MUL);
                    c.era    = era_prod[umcd_pkg::ERA_SH +: 11];
                    sec_prod = 55'(c.msd) * 55'(umcd_pkg::SEC_MUL);
                    c.sod    = sec_prod[umcd_pkg::SEC_SH +: 17];
                end
                ST_DOE: begin
                    c.doe     = 18'(c.q - 28'(c.era) * 28'(umcd_pkg::DAYS_PER_ERA));
                    c.millis  = 10'(c.msd - 27'(c.sod) * 27'(umcd_pkg::MS_PER_SEC));
                    hour_prod = 35'(c.sod) * 35'(umcd_pkg::HOUR_MUL);
                    c.hour    = hour_prod[umcd_pkg::HOUR_SH +: 5];
                end
                ST_CENT: begin
                    quad_prod = 37'(c.doe) * 37'(umcd_pkg::QUAD_MUL);
                    c.a       = quad_prod[umcd_pkg::QUAD_SH +: 7];
                    b_v       = '0;
                    for (int i = 1; i <= 4; i++) begin
                        b_v = b_v + 3'(c.doe >= 18'(i * umcd_pkg::DAYS_PER_CENT));
                    end
                    c.b       = b_v;
                    c.c       = (c.doe == 18'(umcd_pkg::DAYS_PER_ERA - 1));
                    c.trem    = 12'(c.sod - 17'(c.hour) * 17'(umcd_pkg::SEC_PER_HOUR));
                    era_off   = $signed(YEAR_W'(c.era)) - $signed(YEAR_W'(umcd_pkg::ERA_BIAS));
                    c.era_years = era_off * $signed(YEAR_W'(400));
                end
                ST_SUM: begin
                    c.t      = 18'(19'(c.doe) - 19'(c.a) + 19'(c.b) - 19'(c.c));
                    min_prod = 25'(c.trem) * 25'(umcd_pkg::MIN_MUL);
                    c.minute = min_prod[umcd_pkg::MIN_SH +: 6];
                end
                ST_YOE: begin
                    year_prod = 37'(c.t) * 37'(umcd_pkg::YEAR_MUL);
                    c.yoe     = year_prod[umcd_pkg::YEAR_SH +: 9];
                    c.second  = 6'(c.trem - 12'(c.minute) * 12'(umcd_pkg::SEC_PER_MIN));
                end
                ST_DOY: begin
                    cent  = 2'(c.yoe >= 9'd100) + 2'(c.yoe >= 9'd200) + 2'(c.yoe >= 9'd300);
                    yday  = 18'(c.yoe) * 18'(umcd_pkg::DAYS_PER_YEAR) + 18'(c.yoe >> 2)
                            - 18'(cent);
                    c.doy = 9'(c.doe - yday);
                end
                ST_MP: begin
                    mp_v = '0;
                    for (int i = 1; i < 12; i++) begin
                        if (c.doy >= umcd_pkg::day_base(4'(i))) begin
                            mp_v = 4'(i);
                        end
                    end
                    c.mp = mp_v;
                end
                ST_DATE: begin
                    c.day   = 5'(c.doy - umcd_pkg::day_base(c.mp) + 9'd1);
                    c.month = (c.mp < 4'd10) ? c.mp + 4'd3 : c.mp - 4'd9;
                    c.year  = $signed(YEAR_W'(c.yoe)) + c.era_years
                              + $signed(YEAR_W'(c.mp >= 4'd10));
                end
                default: begin
                end
            endcase
            st_next[k] = c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (en[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];

    always_comb begin
        out_word.cal_year     = st_reg[STAGES-1].year;
        out_word.cal_month    = st_reg[STAGES-1].month;
        out_word.cal_day      = st_reg[STAGES-1].day;
        out_word.clock_hour   = st_reg[STAGES-1].hour;
        out_word.clock_minute = st_reg[STAGES-1].minute;
        out_word.clock_second = st_reg[STAGES-1].second;
        out_word.milli_part   = st_reg[STAGES-1].millis;
        out_word.out_of_range = st_reg[STAGES-1].oor;
    end

    `UMCD_ASSERT(a_doe_in_era, v_reg[ST_DOE] |-> st_reg[ST_DOE].doe < DOE_END, "day of era too large")
    `UMCD_ASSERT(a_doy_in_year, v_reg[ST_DOY] |-> st_reg[ST_DOY].doy <= 9'd365, "day of year too large")

endmodule

>>> rtl/core/unix_millis_to_civil_date.sv
// Converts signed Unix millisecond timestamps into proleptic Gregorian date and time of day
// in a configured zone. One word is accepted every clock cycle when the output side keeps up.
// Each word passes through one input stage, seven stages of the day divider retiring four
// quotient bits each, eight calendar and clock stages and the output register. Every stage
// holds its word independently, so gaps on either side are squeezed out and a stalled output
// keeps taking words until the pipeline is full. The zone offset in minutes is to be written
// over the cfg channel only while no word is in flight; the block does not enforce this. It
// applies to words accepted from the next cycle on. Inputs beyond 8.64e15 ms either way
// return m_out_of_range set with all other fields zero.
`timescale 1ns / 1ps

`include "unix_millis_to_civil_date_macros.svh"

module unix_millis_to_civil_date (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wvalid,
    output logic                                 cfg_wready,
    input  logic signed [umcd_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [umcd_pkg::IN_W-1:0]     s_epoch_ms,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [umcd_pkg::YEAR_W-1:0]   m_cal_year,
    output logic [3:0]                           m_cal_month,
    output logic [4:0]                           m_cal_day,
    output logic [4:0]                           m_clock_hour,
    output logic [5:0]                           m_clock_minute,
    output logic [5:0]                           m_clock_second,
    output logic [9:0]                           m_milli_part,
    output logic                                 m_out_of_range
);

    logic               div_in_valid;
    logic               div_in_ready;
    umcd_pkg::div_in_t  div_in_word;
    logic               civ_in_valid;
    logic               civ_in_ready;
    umcd_pkg::div_out_t civ_in_word;
    logic               civ_valid;
    logic               civ_ready;
    umcd_pkg::result_t  civ_word;
    logic               m_valid_reg;
    umcd_pkg::result_t  res_reg;
    umcd_pkg::result_t  res_next;

    umcd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wvalid  (cfg_wvalid),
        .cfg_wready  (cfg_wready),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_epoch_ms (s_epoch_ms),
        .out_valid   (div_in_valid),
        .out_ready   (div_in_ready),
        .out_word    (div_in_word)
    );

    umcd_daydiv u_daydiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_in_valid),
        .in_ready  (div_in_ready),
        .in_word   (div_in_word),
        .out_valid (civ_in_valid),
        .out_ready (civ_in_ready),
        .out_word  (civ_in_word)
    );

    umcd_civil u_civil (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (civ_in_valid),
        .in_ready  (civ_in_ready),
        .in_word   (civ_in_word),
        .out_valid (civ_valid),
        .out_ready (civ_ready),
        .out_word  (civ_word)
    );

    // out of range words carry only the flag
    always_comb begin
        if (civ_word.out_of_range) begin
            res_next              = '0;
            res_next.out_of_range = 1'b1;
        end else begin
            res_next = civ_word;
        end
    end

    assign civ_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (civ_ready) begin
            m_valid_reg <= civ_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (civ_ready) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cal_year     = res_reg.cal_year;
    assign m_cal_month    = res_reg.cal_month;
    assign m_cal_day      = res_reg.cal_day;
    assign m_clock_hour   = res_reg.clock_hour;
    assign m_clock_minute = res_reg.clock_minute;
    assign m_clock_second = res_reg.clock_second;
    assign m_milli_part   = res_reg.milli_part;
    assign m_out_of_range = res_reg.out_of_range;

    `UMCD_ASSERT(a_date_fields, m_valid && !m_out_of_range |-> (m_cal_month >= 4'd1) && (m_cal_month <= 4'd12) && (m_cal_day >= 5'd1) && (m_cal_day <= 5'd31), "date field out of range")
    `UMCD_ASSERT(a_time_fields, m_valid && !m_out_of_range |-> (m_clock_hour < 5'd24) && (m_clock_minute < 6'd60) && (m_clock_second < 6'd60) && (m_milli_part < 10'd1000), "time field out of range")
    `UMCD_ASSERT_ALWAYS(a_empty_after_reset, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

>>> test/civil_date_checker.sv
// checker that predicts civil date and time of day for each accepted word and compares results
`timescale 1ns / 1ps

module civil_date_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wvalid,
    input  logic                                 cfg_wready,
    input  logic signed [umcd_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [umcd_pkg::IN_W-1:0]     s_epoch_ms,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [umcd_pkg::YEAR_W-1:0]   m_cal_year,
    input  logic [3:0]                           m_cal_month,
    input  logic [4:0]                           m_cal_day,
    input  logic [4:0]                           m_clock_hour,
    input  logic [5:0]                           m_clock_minute,
    input  logic [5:0]                           m_clock_second,
    input  logic [9:0]                           m_milli_part,
    input  logic                                 m_out_of_range,
    output int                                   fail_count,
    output int                                   pending
);

    localparam longint RANGE_MS = 64'sd8640000000000000;

    logic signed [umcd_pkg::CFG_W-1:0] zone_min = '0;
    umcd_pkg::result_t                 expected_dates[$];
    int                                mismatches = 0;

    assign fail_count = mismatches;

    function automatic umcd_pkg::result_t civil_date_of(
        input logic signed [umcd_pkg::IN_W-1:0]  stamp,
        input logic signed [umcd_pkg::CFG_W-1:0] zone
    );
        longint ms, adj, millis, secs, sod, days;
        longint shifted, era, doe, yoe, doy, mp, day, month, year;
        umcd_pkg::result_t r;
        r  = '0;
        ms = stamp;
        if (ms > RANGE_MS || ms < -RANGE_MS) begin
            r.out_of_range = 1'b1;
            return r;
        end
        adj = ms + longint'(zone) * 64'sd60000;
        // floor division, remainders never negative
        millis = adj % 1000;
        secs   = adj / 1000;
        if (millis < 0) begin
            millis += 1000;
            secs   -= 1;
        end
        sod  = secs % 86400;
        days = secs / 86400;
        if (sod < 0) begin
            sod  += 86400;
            days -= 1;
        end
        // march-based years in 400-year eras
        shifted = days + 719468;
        era     = (shifted >= 0 ? shifted : shifted - 146096) / 146097;
        doe     = shifted - era * 146097;
        yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy     = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp      = (5 * doy + 2) / 153;
        day     = doy - (153 * mp + 2) / 5 + 1;
        month   = mp < 10 ? mp + 3 : mp - 9;
        year    = yoe + era * 400 + (month <= 2 ? 1 : 0);
        r.cal_year     = 20'(year);
        r.cal_month    = 4'(month);
        r.cal_day      = 5'(day);
        r.clock_hour   = 5'(sod / 3600);
        r.clock_minute = 6'((sod % 3600) / 60);
        r.clock_second = 6'(sod % 60);
        r.milli_part   = 10'(millis);
        return r;
    endfunction

    always @(posedge aclk) begin
        umcd_pkg::result_t seen;
        umcd_pkg::result_t want;
        if (!aresetn) begin
            zone_min = '0;
            expected_dates.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen.cal_year     = m_cal_year;
                seen.cal_month    = m_cal_month;
                seen.cal_day      = m_cal_day;
                seen.clock_hour   = m_clock_hour;
                seen.clock_minute = m_clock_minute;
                seen.clock_second = m_clock_second;
                seen.milli_part   = m_milli_part;
                seen.out_of_range = m_out_of_range;
                if (expected_dates.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result word with none expected", $realtime);
                    mismatches++;
                end else begin
                    want = expected_dates.pop_front();
                    if (seen.cal_year !== want.cal_year || seen.cal_month !== want.cal_month ||
                        seen.cal_day !== want.cal_day || seen.clock_hour !== want.clock_hour ||
                        seen.clock_minute !== want.clock_minute ||
                        seen.clock_second !== want.clock_second ||
                        seen.milli_part !== want.milli_part ||
                        seen.out_of_range !== want.out_of_range) begin
                        if (mismatches < 10)
                            $display("%0t: expected %0d-%0d-%0d %0d:%0d:%0d.%0d oor %0b, got %0d-%0d-%0d %0d:%0d:%0d.%0d oor %0b",
                                     $realtime, want.cal_year, want.cal_month, want.cal_day,
                                     want.clock_hour, want.clock_minute, want.clock_second,
                                     want.milli_part, want.out_of_range,
                                     seen.cal_year, seen.cal_month, seen.cal_day,
                                     seen.clock_hour, seen.clock_minute, seen.clock_second,
                                     seen.milli_part, seen.out_of_range);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_dates.push_back(civil_date_of(s_epoch_ms, zone_min));
            if (cfg_wvalid && cfg_wready)
                zone_min = cfg_wdata;
        end
        pending = expected_dates.size();
    end

endmodule

>>> test/testbench.sv
// top of the timestamp converter test: clock, reset, stimulus, output stalls and verdict
`timescale 1ns / 1ps

module testbench;

    typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_CADENCE} rx_mode_t;

    logic                                 aclk        = 1'b0;
    logic                                 aresetn     = 1'b0;
    logic                                 cfg_wvalid  = 1'b0;
    logic                                 cfg_wready;
    logic signed [umcd_pkg::CFG_W-1:0]    cfg_wdata   = '0;
    logic                                 s_valid     = 1'b0;
    logic                                 s_ready;
    logic signed [umcd_pkg::IN_W-1:0]     s_epoch_ms  = '0;
    logic                                 m_valid;
    logic                                 m_ready     = 1'b0;
    logic signed [umcd_pkg::YEAR_W-1:0]   m_cal_year;
    logic [3:0]                           m_cal_month;
    logic [4:0]                           m_cal_day;
    logic [4:0]                           m_clock_hour;
    logic [5:0]                           m_clock_minute;
    logic [5:0]                           m_clock_second;
    logic [9:0]                           m_milli_part;
    logic                                 m_out_of_range;
    int                                   fail_count;
    int                                   pending;
    int                                   hold_count  = 0;

    localparam longint RANGE_MS = 64'sd8640000000000000;
    localparam longint DAY_MS   = 64'sd86400000;

    // epoch, day and second edges, leap day, era edges, range limits, field extremes
    longint edge_stamps[23] = '{
        64'sd0, -64'sd1, 64'sd1, 64'sd999, 64'sd1000, -64'sd1000, -64'sd1001,
        64'sd86399999, 64'sd86400000, -64'sd86400000, -64'sd86400001,
        64'sd951782400000, 64'sd951868800000, 64'sd946684799999, -64'sd2203891200000,
        -64'sd62162035200000, -64'sd62162035200001,
        64'sd8640000000000000, -64'sd8640000000000000,
        64'sd8640000000000001, -64'sd8640000000000001,
        64'sd9007199254740991, -64'sd9007199254740992
    };

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    unix_millis_to_civil_date dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wvalid     (cfg_wvalid),
        .cfg_wready     (cfg_wready),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_epoch_ms     (s_epoch_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cal_year     (m_cal_year),
        .m_cal_month    (m_cal_month),
        .m_cal_day      (m_cal_day),
        .m_clock_hour   (m_clock_hour),
        .m_clock_minute (m_clock_minute),
        .m_clock_second (m_clock_second),
        .m_milli_part   (m_milli_part),
        .m_out_of_range (m_out_of_range)
    );

    civil_date_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wvalid     (cfg_wvalid),
        .cfg_wready     (cfg_wready),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_epoch_ms     (s_epoch_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cal_year     (m_cal_year),
        .m_cal_month    (m_cal_month),
        .m_cal_day      (m_cal_day),
        .m_clock_hour   (m_clock_hour),
        .m_clock_minute (m_clock_minute),
        .m_clock_second (m_clock_second),
        .m_milli_part   (m_milli_part),
        .m_out_of_range (m_out_of_range),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    function automatic logic [umcd_pkg::IN_W-1:0] random_epoch();
        longint v;
        longint days;
        longint jitter;
        int     kind;
        kind   = $urandom_range(0, 9);
        jitter = longint'($urandom_range(0, 4));
        jitter = jitter - 2;
        case (kind)
            0, 1: v = {$urandom, $urandom};
            2: begin
                v = RANGE_MS + jitter;
                if ($urandom_range(0, 1)) v = -v;
            end
            3, 4: begin
                days = longint'($urandom_range(0, 400000));
                v    = (days - 200000) * DAY_MS + jitter * 60000 + jitter;
            end
            5, 6: begin
                v = {$urandom, $urandom};
                v = v >>> 17;
            end
            7: begin
                v = {$urandom, $urandom};
                v = v >>> 11;
            end
            8: begin
                v = longint'($urandom_range(0, 2000000));
                v = v - 1000000;
            end
            default: begin
                days = longint'($urandom_range(0, 2));
                v    = longint'($urandom_range(0, 86400000));
                v    = RANGE_MS - days * DAY_MS - v;
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v[umcd_pkg::IN_W-1:0];
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic push_word(input logic [umcd_pkg::IN_W-1:0] stamp);
        s_epoch_ms = stamp;
        s_valid    = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_and_set_zone(input logic signed [umcd_pkg::CFG_W-1:0] zone);
        s_valid = 1'b0;
        wait (pending == 0);
        @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_wdata  = zone;
        cfg_wvalid = 1'b1;
        do @(posedge aclk); while (!cfg_wready);
        @(negedge aclk);
        cfg_wvalid = 1'b0;
    endtask

    task automatic feed_random(input int count, input bit with_hold);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 32);
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == count / 3)
                hold_count++;
            push_word(random_epoch());
            burst_left--;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
                if (gap > 0) begin
                    s_valid = 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 160)
                                                         : $urandom_range(1, 32);
            end
        end
    endtask

    // output stalls: random modes, with a long hold-off on request
    initial begin
        rx_mode_t mode;
        int       span;
        int       tick;
        int       served;
        mode   = RX_FREE;
        span   = 0;
        tick   = 0;
        served = 0;
        forever begin
            @(negedge aclk);
            if (served != hold_count) begin
                m_ready = 1'b0;
                repeat (100) @(negedge aclk);
                served++;
            end
            if (span == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                span = $urandom_range(16, 96);
            end
            span--;
            tick++;
            case (mode)
                RX_FREE:   m_ready = 1'b1;
                RX_HALF:   m_ready = 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready = ($urandom_range(0, 3) == 0);
                default:   m_ready = (tick % 5) != 0;
            endcase
        end
    end

    initial begin
        logic signed [umcd_pkg::CFG_W-1:0] zones[8];
        zones = '{-12'sd1439, 12'sd1439, -12'sd2048, 12'sd2047, 12'sd0, -12'sd1, 12'sd0, 12'sd0};
        zones[6] = 12'($urandom_range(0, 4095));
        zones[7] = 12'($urandom_range(0, 4095));
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        foreach (edge_stamps[i])
            push_word(edge_stamps[i][umcd_pkg::IN_W-1:0]);
        foreach (zones[p]) begin
            drain_and_set_zone(zones[p]);
            feed_random(250, p % 2 == 0);
        end
        s_valid = 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("unix_millis_to_civil_date verification clean");
        else
            $display("unix_millis_to_civil_date verification failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("unix_millis_to_civil_date verification failed");
        $finish;
    end

endmodule
